// ----- sv/posm_pkg.sv -----
// Package for the pump overheat state machine.
// Holds the mode, event, opcode and register index codes, widths and reset values.
// No dependencies.

package posm_pkg;

   // Default width of the trip, recovery and on-time counters.
   localparam int TIMER_BITS_DEF = 32;

   // Field widths.
   localparam int LEVEL_W      = 16;
   localparam int TICKS_W      = 32;
   localparam int ROUNDS_W     = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // Register reset values.
   localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST     = 16'd8000;
   localparam logic [LEVEL_W-1:0]  MIN_LEVEL_RST     = 16'd2000;
   localparam logic [TICKS_W-1:0]  TRIP_TICKS_RST    = 32'd600000;
   localparam logic [TICKS_W-1:0]  RECOVER_TICKS_RST = 32'd300000;
   localparam logic [TICKS_W-1:0]  MAX_ON_TICKS_RST  = 32'd1800000;
   localparam logic [ROUNDS_W-1:0] MAX_ROUNDS_RST    = 8'd3;

   // Pump modes.
   typedef enum logic [1:0] {
      MODE_STOP = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_HOT  = 2'd2
   } mode_type;

   // Events reported with each result.
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_START   = 3'd1,
      EV_STOP    = 3'd2,
      EV_HOT     = 3'd3,
      EV_RECOVER = 3'd4,
      EV_MAXON   = 3'd5
   } event_type;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LEVEL = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_LEVEL     = 3'd0,
      CSR_MIN_LEVEL     = 3'd1,
      CSR_TRIP_TICKS    = 3'd2,
      CSR_RECOVER_TICKS = 3'd3,
      CSR_MAX_ON_TICKS  = 3'd4,
      CSR_MAX_ROUNDS    = 3'd5
   } csr_index_type;

endpackage

// ----- sv/pump_overheat_state_machine.sv -----
// Top level of the pump overheat state machine: request register, state update
// and result register. Depends on posm_pkg for codes, widths and reset values.

// The block takes one request per cycle unless a held result stalls it, and
// gives one result per request. A request is captured in an input register;
// when the result register is free or drains, one combinational pass updates
// the pump mode, the trip, recovery and on-time counters and the round count
// and loads the result register, from which the result transfers when the
// result side is ready. The state is updated in that same cycle, so the
// following request sees it at once. A held result stalls the input register
// only, and the configuration port is always ready. The user must write
// configuration only while no request is in flight; the block does not enforce it.

module pump_overheat_state_machine #(
   parameter int TIMER_BITS = posm_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [posm_pkg::LEVEL_W-1:0]        req_water_level,
   input  logic                                req_water_valid,
   input  logic                                req_failsafe_latched,
   input  logic                                req_quiet_hours,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pump_on,
   output logic [1:0]                          rsp_pump_state,
   output logic [2:0]                          rsp_event_res,
   output logic [posm_pkg::ROUNDS_W-1:0]       rsp_rounds,
   output logic                                rsp_blink_fast,
   // Configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [posm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [posm_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Compare width wide enough for both counters and tick registers.
   localparam int CW = (TIMER_BITS > posm_pkg::TICKS_W) ? TIMER_BITS : posm_pkg::TICKS_W;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
   localparam logic [posm_pkg::ROUNDS_W-1:0] ROUNDS_W_ONE = posm_pkg::ROUNDS_W'(1);

   // Configuration registers.
   logic [posm_pkg::LEVEL_W-1:0]  max_level_ff, min_level_ff;
   logic [posm_pkg::TICKS_W-1:0]  trip_ticks_ff, recover_ticks_ff, max_on_ticks_ff;
   logic [posm_pkg::ROUNDS_W-1:0] max_rounds_ff;

   // Input register.
   logic                          in_valid_ff;
   posm_pkg::opcode_type          in_opcode_ff;
   logic [posm_pkg::LEVEL_W-1:0]  in_level_ff;
   logic                          in_wvalid_ff, in_refuse_ff, in_quiet_ff;

   // Controller state.
   posm_pkg::mode_type            mode_ff, mode_in;
   logic [TIMER_BITS-1:0]         trip_left_ff, trip_left_in;
   logic [TIMER_BITS-1:0]         recover_left_ff, recover_left_in;
   logic [TIMER_BITS-1:0]         on_time_ff, on_time_in;
   logic [posm_pkg::ROUNDS_W-1:0] round_count_ff, round_count_in;
   logic [posm_pkg::LEVEL_W-1:0]  last_level_ff, last_level_in;
   logic                          last_valid_ff, last_valid_in;
   logic                          fast_blink_ff, fast_blink_in;
   posm_pkg::event_type           event_in;

   // Result register.
   logic                          rsp_valid_ff;
   posm_pkg::mode_type            rsp_mode_ff;
   posm_pkg::event_type           rsp_event_ff;
   logic [posm_pkg::ROUNDS_W-1:0] rsp_rounds_ff;
   logic                          rsp_blink_ff;

   logic                          process;
   logic [posm_pkg::LEVEL_W-1:0]  threshold;
   logic                          level_usable;

   // Timer load: saturate to the counter range, a zero value loads as one.
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [posm_pkg::TICKS_W-1:0] v);
      logic [CW-1:0] v_ext;
      v_ext = CW'(v);
      if (v_ext > CW'(TMAX)) begin
         return TMAX;
      end else if (v == '0) begin
         return TIMER_BITS'(1);
      end else begin
         return v_ext[TIMER_BITS-1:0];
      end
   endfunction

   // Handshake: the input register moves on when the result register is free or drains.
   assign process   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;
   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff     <= posm_pkg::MAX_LEVEL_RST;
         min_level_ff     <= posm_pkg::MIN_LEVEL_RST;
         trip_ticks_ff    <= posm_pkg::TRIP_TICKS_RST;
         recover_ticks_ff <= posm_pkg::RECOVER_TICKS_RST;
         max_on_ticks_ff  <= posm_pkg::MAX_ON_TICKS_RST;
         max_rounds_ff    <= posm_pkg::MAX_ROUNDS_RST;
      end else if (csr_valid) begin
         case (posm_pkg::csr_index_type'(csr_index))
            posm_pkg::CSR_MAX_LEVEL:     max_level_ff     <= csr_data[posm_pkg::LEVEL_W-1:0];
            posm_pkg::CSR_MIN_LEVEL:     min_level_ff     <= csr_data[posm_pkg::LEVEL_W-1:0];
            posm_pkg::CSR_TRIP_TICKS:    trip_ticks_ff    <= csr_data[posm_pkg::TICKS_W-1:0];
            posm_pkg::CSR_RECOVER_TICKS: recover_ticks_ff <= csr_data[posm_pkg::TICKS_W-1:0];
            posm_pkg::CSR_MAX_ON_TICKS:  max_on_ticks_ff  <= csr_data[posm_pkg::TICKS_W-1:0];
            posm_pkg::CSR_MAX_ROUNDS:    max_rounds_ff    <= csr_data[posm_pkg::ROUNDS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= posm_pkg::opcode_type'(req_opcode);
         in_level_ff  <= req_water_level;
         in_wvalid_ff <= req_water_valid;
         in_refuse_ff <= req_failsafe_latched;
         in_quiet_ff  <= req_quiet_hours;
      end
   end

   // Next state and event for the request in the input register.
   always_comb begin
      mode_in         = mode_ff;
      trip_left_in    = trip_left_ff;
      recover_left_in = recover_left_ff;
      on_time_in      = on_time_ff;
      round_count_in  = round_count_ff;
      last_level_in   = last_level_ff;
      last_valid_in   = last_valid_ff;
      fast_blink_in   = fast_blink_ff;
      event_in        = posm_pkg::EV_NONE;
      threshold       = min_level_ff;
      level_usable    = 1'b0;

      case (in_opcode_ff)
         posm_pkg::OP_TICK: begin
            // On-time counts running ticks and saturates.
            if (mode_ff == posm_pkg::MODE_RUN && on_time_ff != TMAX) begin
               on_time_in = on_time_ff + TIMER_BITS'(1);
            end
            if (trip_left_ff != '0) begin
               trip_left_in = trip_left_ff - TIMER_BITS'(1);
               // Trip expiry forces cooldown unless the failsafe refuses it.
               if (trip_left_ff == TIMER_BITS'(1) && !in_refuse_ff &&
                   mode_ff != posm_pkg::MODE_HOT) begin
                  fast_blink_in   = 1'b1;
                  mode_in         = posm_pkg::MODE_HOT;
                  on_time_in      = '0;
                  recover_left_in = timer_load(recover_ticks_ff);
                  event_in        = posm_pkg::EV_HOT;
               end
            end else if (recover_left_ff != '0) begin
               recover_left_in = recover_left_ff - TIMER_BITS'(1);
               // Recovery: back to stopped, count a round, maybe restart.
               if (recover_left_ff == TIMER_BITS'(1)) begin
                  if (!in_refuse_ff) begin
                     fast_blink_in = 1'b0;
                  end
                  mode_in    = posm_pkg::MODE_STOP;
                  on_time_in = '0;
                  if (round_count_ff != '1) begin
                     round_count_in = round_count_ff + ROUNDS_W_ONE;
                  end
                  threshold    = (round_count_in < max_rounds_ff) ? max_level_ff : min_level_ff;
                  level_usable = last_valid_ff && last_level_ff != '0;
                  // A restart is only ever a start from stopped; a high level does nothing.
                  if (!in_quiet_ff && level_usable && last_level_ff < threshold &&
                      !in_refuse_ff) begin
                     mode_in      = posm_pkg::MODE_RUN;
                     trip_left_in = timer_load(trip_ticks_ff);
                  end
                  if (mode_in != posm_pkg::MODE_RUN) begin
                     round_count_in = '0;
                  end
                  event_in = posm_pkg::EV_RECOVER;
               end
            end
            // Max-on limit stops a running pump even under failsafe.
            if (mode_in == posm_pkg::MODE_RUN && CW'(on_time_in) > CW'(max_on_ticks_ff)) begin
               trip_left_in   = '0;
               mode_in        = posm_pkg::MODE_STOP;
               on_time_in     = '0;
               round_count_in = '0;
               event_in       = posm_pkg::EV_MAXON;
            end
         end
         posm_pkg::OP_LEVEL: begin
            // Store the reading, then check it against the lower and upper levels.
            last_level_in = in_level_ff;
            last_valid_in = in_wvalid_ff;
            level_usable  = in_wvalid_ff && in_level_ff != '0;
            if (level_usable && !in_refuse_ff) begin
               if (in_level_ff < min_level_ff) begin
                  if (mode_ff == posm_pkg::MODE_STOP) begin
                     mode_in      = posm_pkg::MODE_RUN;
                     on_time_in   = '0;
                     trip_left_in = timer_load(trip_ticks_ff);
                     event_in     = posm_pkg::EV_START;
                  end
               end else if (in_level_ff > max_level_ff && mode_ff == posm_pkg::MODE_RUN) begin
                  trip_left_in   = '0;
                  mode_in        = posm_pkg::MODE_STOP;
                  on_time_in     = '0;
                  round_count_in = '0;
                  event_in       = posm_pkg::EV_STOP;
               end
            end
         end
         posm_pkg::OP_START: begin
            // Manual start only from stopped.
            if (!in_refuse_ff && mode_ff == posm_pkg::MODE_STOP) begin
               mode_in      = posm_pkg::MODE_RUN;
               on_time_in   = '0;
               trip_left_in = timer_load(trip_ticks_ff);
               event_in     = posm_pkg::EV_START;
            end
         end
         posm_pkg::OP_STOP: begin
            // Manual stop only while running; cooldown goes on.
            if (!in_refuse_ff && mode_ff == posm_pkg::MODE_RUN) begin
               trip_left_in   = '0;
               mode_in        = posm_pkg::MODE_STOP;
               on_time_in     = '0;
               round_count_in = '0;
               event_in       = posm_pkg::EV_STOP;
            end
         end
         default: ;
      endcase
   end

   // Controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= posm_pkg::MODE_STOP;
         trip_left_ff    <= '0;
         recover_left_ff <= '0;
         on_time_ff      <= '0;
         round_count_ff  <= '0;
         last_level_ff   <= '0;
         last_valid_ff   <= 1'b0;
         fast_blink_ff   <= 1'b0;
      end else if (process) begin
         mode_ff         <= mode_in;
         trip_left_ff    <= trip_left_in;
         recover_left_ff <= recover_left_in;
         on_time_ff      <= on_time_in;
         round_count_ff  <= round_count_in;
         last_level_ff   <= last_level_in;
         last_valid_ff   <= last_valid_in;
         fast_blink_ff   <= fast_blink_in;
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (process) begin
         rsp_mode_ff   <= mode_in;
         rsp_event_ff  <= event_in;
         rsp_rounds_ff <= round_count_in;
         rsp_blink_ff  <= fast_blink_in;
      end
   end

   // Result outputs.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pump_on    = (rsp_mode_ff == posm_pkg::MODE_RUN);
   assign rsp_pump_state = rsp_mode_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_rounds     = rsp_rounds_ff;
   assign rsp_blink_fast = rsp_blink_ff;

endmodule

// ----- tb/tb_pump_overheat_state_machine.sv -----
// Self-checking testbench for the pump overheat state machine.
// Runs a directed table, a round saturation run and random phases, and checks
// each result against the table or an internal predictor. Depends on posm_pkg and pump_overheat_state_machine.

module tb_pump_overheat_state_machine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                      LEVEL_W        = posm_pkg::LEVEL_W;
   localparam int                      TICKS_W        = posm_pkg::TICKS_W;
   localparam int                      ROUNDS_W       = posm_pkg::ROUNDS_W;
   localparam int                      CSR_INDEX_W    = posm_pkg::CSR_INDEX_W;
   localparam int                      CSR_DATA_W     = posm_pkg::CSR_DATA_W;
   localparam int                      RAND_PHASES    = 10;
   localparam int                      PHASE_ITEMS    = 100;
   localparam int                      SAT_TICKS      = 560;
   localparam int                      WATCHDOG_LIMIT = 2000;
   localparam int                      MAX_PRINTED    = 100;
   localparam logic [TICKS_W-1:0]      TICKS_MAX      = '1;
   localparam logic [CSR_INDEX_W-1:0]  CSR_SPARE_LO   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0]  CSR_SPARE_HI   = 3'd7;

   typedef struct packed {
      posm_pkg::opcode_type opcode;
      logic [LEVEL_W-1:0]   level;
      logic                 level_valid;
      logic                 failsafe;
      logic                 quiet;
   } pump_request_type;

   typedef struct packed {
      logic                relay;
      logic [1:0]          state;
      logic [2:0]          ev_code;
      logic [ROUNDS_W-1:0] rounds;
      logic                blink;
   } pump_result_type;

   typedef struct {
      bit                     is_csr;
      pump_request_type       rq;
      bit                     typed;
      pump_result_type        want;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_word;
   } stim_row_type;

   // Clock, reset and block ports.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = posm_pkg::OP_TICK;
   logic [LEVEL_W-1:0]        req_water_level = '0;
   logic                      req_water_valid = 1'b0;
   logic                      req_failsafe_latched = 1'b0;
   logic                      req_quiet_hours = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic                      rsp_pump_on;
   logic [1:0]                rsp_pump_state;
   logic [2:0]                rsp_event_res;
   logic [ROUNDS_W-1:0]       rsp_rounds;
   logic                      rsp_blink_fast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = posm_pkg::CSR_MAX_LEVEL;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // Shadow of the configuration registers.
   logic [LEVEL_W-1:0]        cfg_max_level = posm_pkg::MAX_LEVEL_RST;
   logic [LEVEL_W-1:0]        cfg_min_level = posm_pkg::MIN_LEVEL_RST;
   logic [TICKS_W-1:0]        cfg_trip = posm_pkg::TRIP_TICKS_RST;
   logic [TICKS_W-1:0]        cfg_recover = posm_pkg::RECOVER_TICKS_RST;
   logic [TICKS_W-1:0]        cfg_max_on = posm_pkg::MAX_ON_TICKS_RST;
   logic [ROUNDS_W-1:0]       cfg_max_rounds = posm_pkg::MAX_ROUNDS_RST;

   // Predicted pump state.
   posm_pkg::mode_type        pm_mode = posm_pkg::MODE_STOP;
   logic [TICKS_W-1:0]        pm_trip_left = '0;
   logic [TICKS_W-1:0]        pm_recover_left = '0;
   logic [TICKS_W-1:0]        pm_on_time = '0;
   logic [ROUNDS_W-1:0]       pm_rounds = '0;
   logic [LEVEL_W-1:0]        pm_level = '0;
   logic                      pm_level_ok = 1'b0;
   logic                      pm_blink = 1'b0;
   posm_pkg::event_type       pm_event = posm_pkg::EV_NONE;
   logic                      pm_refuse = 1'b0;

   pump_result_type           expected_results[$];
   stim_row_type              directed_rows[$];
   int                        mismatch_count = 0;
   int                        results_seen = 0;
   int                        idle_cycles = 0;
   int                        gap_pct = 20;
   bit                        calm = 1'b0;

   pump_overheat_state_machine u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_water_level      (req_water_level),
      .req_water_valid      (req_water_valid),
      .req_failsafe_latched (req_failsafe_latched),
      .req_quiet_hours      (req_quiet_hours),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pump_on          (rsp_pump_on),
      .rsp_pump_state       (rsp_pump_state),
      .rsp_event_res        (rsp_event_res),
      .rsp_rounds           (rsp_rounds),
      .rsp_blink_fast       (rsp_blink_fast),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #4ns clock = ~clock;

   // A zero register value still arms the timer for one tick.
   function automatic logic [TICKS_W-1:0] load_timer(logic [TICKS_W-1:0] ticks);
      return (ticks == '0) ? TICKS_W'(1) : ticks;
   endfunction

   // Start request: honored only from stopped and without failsafe.
   function automatic void pump_start();
      if (pm_refuse || pm_mode != posm_pkg::MODE_STOP) return;
      pm_mode      = posm_pkg::MODE_RUN;
      pm_on_time   = '0;
      pm_trip_left = load_timer(cfg_trip);
      pm_event     = posm_pkg::EV_START;
   endfunction

   // Stop of a running pump; clears the round count.
   function automatic void halt_pump(posm_pkg::event_type why);
      if (pm_mode != posm_pkg::MODE_RUN) return;
      pm_trip_left = '0;
      pm_mode      = posm_pkg::MODE_STOP;
      pm_on_time   = '0;
      pm_rounds    = '0;
      pm_event     = why;
   endfunction

   // Acts on the stored reading; zero or invalid readings do nothing.
   function automatic void level_check(logic [LEVEL_W-1:0] threshold);
      if (!pm_level_ok || pm_level == '0) return;
      if (pm_level < threshold) pump_start();
      else if (pm_level > cfg_max_level && !pm_refuse) halt_pump(posm_pkg::EV_STOP);
   endfunction

   // Advances the predicted pump by one request and returns its result.
   function automatic pump_result_type pump_step(pump_request_type rq);
      pump_result_type res;
      pm_refuse = rq.failsafe;
      pm_event  = posm_pkg::EV_NONE;
      case (rq.opcode)
         posm_pkg::OP_TICK: begin
            if (pm_mode == posm_pkg::MODE_RUN && pm_on_time != TICKS_MAX)
               pm_on_time = pm_on_time + TICKS_W'(1);
            if (pm_trip_left != '0) begin
               pm_trip_left = pm_trip_left - TICKS_W'(1);
               // Trip expiry; under failsafe the timer is simply spent.
               if (pm_trip_left == '0 && !pm_refuse && pm_mode != posm_pkg::MODE_HOT) begin
                  pm_blink        = 1'b1;
                  pm_mode         = posm_pkg::MODE_HOT;
                  pm_on_time      = '0;
                  pm_recover_left = load_timer(cfg_recover);
                  pm_event        = posm_pkg::EV_HOT;
               end
            end else if (pm_recover_left != '0) begin
               pm_recover_left = pm_recover_left - TICKS_W'(1);
               // End of cooldown: count a round and maybe resume.
               if (pm_recover_left == '0) begin
                  if (!pm_refuse) pm_blink = 1'b0;
                  pm_mode    = posm_pkg::MODE_STOP;
                  pm_on_time = '0;
                  if (pm_rounds != '1) pm_rounds = pm_rounds + ROUNDS_W'(1);
                  if (!rq.quiet)
                     level_check((pm_rounds < cfg_max_rounds) ? cfg_max_level : cfg_min_level);
                  if (pm_mode != posm_pkg::MODE_RUN) pm_rounds = '0;
                  pm_event = posm_pkg::EV_RECOVER;
               end
            end
            if (pm_mode == posm_pkg::MODE_RUN && pm_on_time > cfg_max_on)
               halt_pump(posm_pkg::EV_MAXON);
         end
         posm_pkg::OP_LEVEL: begin
            pm_level    = rq.level;
            pm_level_ok = rq.level_valid;
            level_check(cfg_min_level);
         end
         posm_pkg::OP_START: pump_start();
         default: if (!pm_refuse) halt_pump(posm_pkg::EV_STOP);
      endcase
      res.relay   = (pm_mode == posm_pkg::MODE_RUN);
      res.state   = pm_mode;
      res.ev_code = pm_event;
      res.rounds  = pm_rounds;
      res.blink   = pm_blink;
      return res;
   endfunction

   // Appends one request row to the directed table, optionally with its result.
   function automatic void add_row(posm_pkg::opcode_type op, logic [LEVEL_W-1:0] lvl,
                                   logic wv, logic fs, logic qh, bit typed = 1'b0,
                                   logic relay = 1'b0,
                                   posm_pkg::mode_type st = posm_pkg::MODE_STOP,
                                   posm_pkg::event_type ev = posm_pkg::EV_NONE,
                                   logic [ROUNDS_W-1:0] rnd = '0, logic blk = 1'b0);
      stim_row_type row;
      row.is_csr   = 1'b0;
      row.rq       = {op, lvl, wv, fs, qh};
      row.typed    = typed;
      row.want     = {relay, st, ev, rnd, blk};
      row.csr_idx  = posm_pkg::CSR_MAX_LEVEL;
      row.csr_word = '0;
      directed_rows.push_back(row);
   endfunction

   // Appends one register write to the directed table.
   function automatic void add_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] word);
      stim_row_type row;
      row.is_csr   = 1'b1;
      row.rq       = '0;
      row.typed    = 1'b0;
      row.want     = '0;
      row.csr_idx  = idx;
      row.csr_word = word;
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at %0t, result %0d: %s got %0d expected %0d",
                  $time, results_seen, what, got, want);
   endtask

   // Presents one request, waits for its transfer and records the expected result.
   task automatic send_request(pump_request_type rq, bit typed, pump_result_type want);
      pump_result_type predicted;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_opcode           <= rq.opcode;
      req_water_level      <= rq.level;
      req_water_valid      <= rq.level_valid;
      req_failsafe_latched <= rq.failsafe;
      req_quiet_hours      <= rq.quiet;
      req_valid            <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = pump_step(rq);
      expected_results.push_back(typed ? want : predicted);
   endtask

   // Lowers the request valid and waits until every result has been seen.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write transfer; the shadow copy follows at the transfer.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] word);
      csr_index <= idx;
      csr_data  <= word;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         posm_pkg::CSR_MAX_LEVEL:     cfg_max_level  = word[LEVEL_W-1:0];
         posm_pkg::CSR_MIN_LEVEL:     cfg_min_level  = word[LEVEL_W-1:0];
         posm_pkg::CSR_TRIP_TICKS:    cfg_trip       = word;
         posm_pkg::CSR_RECOVER_TICKS: cfg_recover    = word;
         posm_pkg::CSR_MAX_ON_TICKS:  cfg_max_on     = word;
         posm_pkg::CSR_MAX_ROUNDS:    cfg_max_rounds = word[ROUNDS_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result checker: each result transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      pump_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, event", 32'(rsp_event_res),
                            32'(posm_pkg::EV_NONE));
         end else begin
            want = expected_results.pop_front();
            if (rsp_pump_on !== want.relay)
               report_mismatch("pump_on", 32'(rsp_pump_on), 32'(want.relay));
            if (rsp_pump_state !== want.state)
               report_mismatch("pump_state", 32'(rsp_pump_state), 32'(want.state));
            if (rsp_event_res !== want.ev_code)
               report_mismatch("event_res", 32'(rsp_event_res), 32'(want.ev_code));
            if (rsp_rounds !== want.rounds)
               report_mismatch("rounds", 32'(rsp_rounds), 32'(want.rounds));
            if (rsp_blink_fast !== want.blink)
               report_mismatch("blink_fast", 32'(rsp_blink_fast), 32'(want.blink));
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side backpressure in random bursts, none in the calm tail.
   initial begin : rsp_backpressure
      int run_len;
      wait (reset === 1'b0);
      forever begin
         run_len = $urandom_range(1, 60);
         repeat (run_len) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Main stimulus: directed table, round saturation run, then random phases.
   initial begin : stimulus
      pump_request_type    rq;
      logic [LEVEL_W-1:0]  lvl_hi, lvl_lo;
      logic [TICKS_W-1:0]  trip, rec, on_lim;
      logic [ROUNDS_W-1:0] rnd_cap;
      logic [31:0]         junk;
      int                  fs_pct, quiet_pct, pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table with default registers, then short timers.
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_LEVEL, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_LEVEL, 16'd0,    1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_LEVEL, 16'd1000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_LEVEL, 16'd1000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_LEVEL, 16'd1000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_START);
      add_row(posm_pkg::OP_START, 16'd0,    1'b0, 1'b0, 1'b0);
      add_row(posm_pkg::OP_STOP,  16'd0,    1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_LEVEL, 16'd8001, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_STOP);
      add_row(posm_pkg::OP_START, 16'hFFFF, 1'b1, 1'b0, 1'b1);
      add_row(posm_pkg::OP_STOP,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_STOP);
      add_csr(posm_pkg::CSR_TRIP_TICKS, 32'd0);
      add_csr(posm_pkg::CSR_RECOVER_TICKS, 32'd1);
      add_csr(posm_pkg::CSR_MAX_ON_TICKS, 32'd1);
      add_csr(CSR_SPARE_LO, 32'hFFFF_FFFF);
      add_csr(CSR_SPARE_HI, 32'hFFFF_FFFF);
      // Trip timer loaded with zero fires at the next tick; stop during cooldown.
      add_row(posm_pkg::OP_START, 16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_START);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_HOT,  posm_pkg::EV_HOT, 8'd0, 1'b1);
      add_row(posm_pkg::OP_STOP,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_HOT,  posm_pkg::EV_NONE, 8'd0, 1'b1);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_RECOVER);
      // Trip under failsafe is spent, then the max-on stop ignores failsafe.
      add_row(posm_pkg::OP_START, 16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_START);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_NONE);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_MAXON);
      // Recovery under failsafe keeps fast blink; a later recovery resumes.
      add_row(posm_pkg::OP_LEVEL, 16'd100,  1'b1, 1'b0, 1'b0);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b0, 1'b0);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
              posm_pkg::MODE_STOP, posm_pkg::EV_RECOVER, 8'd0, 1'b1);
      add_row(posm_pkg::OP_START, 16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_START, 8'd0, 1'b1);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b0, 1'b0);
      add_row(posm_pkg::OP_TICK,  16'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
              posm_pkg::MODE_RUN,  posm_pkg::EV_RECOVER, 8'd1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_idle();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_word);
         end else begin
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Back-to-back overheat rounds until the round count saturates.
      wait_idle();
      write_csr(posm_pkg::CSR_MAX_LEVEL, 32'd8000);
      write_csr(posm_pkg::CSR_MIN_LEVEL, 32'd2000);
      write_csr(posm_pkg::CSR_TRIP_TICKS, 32'd1);
      write_csr(posm_pkg::CSR_RECOVER_TICKS, 32'd1);
      write_csr(posm_pkg::CSR_MAX_ON_TICKS, TICKS_MAX);
      write_csr(posm_pkg::CSR_MAX_ROUNDS, 32'd255);
      send_request({posm_pkg::OP_LEVEL, 16'd1000, 1'b1, 1'b0, 1'b0}, 1'b0, '0);
      for (int n = 0; n < SAT_TICKS; n++)
         send_request({posm_pkg::OP_TICK, 16'($urandom), 1'($urandom), 1'b0, 1'b0}, 1'b0, '0);

      // Random phases, each with its own register settings.
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         wait_idle();
         calm      = (phase == RAND_PHASES - 1);
         gap_pct   = calm ? 0 : $urandom_range(0, 2) * 15;
         fs_pct    = $urandom_range(0, 12);
         quiet_pct = $urandom_range(0, 50);
         case (phase)
            0: begin
               lvl_hi = '0; lvl_lo = '0; trip = 32'd1; rec = 32'd1; on_lim = 32'd1;
               rnd_cap = '0;
            end
            1: begin
               lvl_hi = '1; lvl_lo = '1; trip = TICKS_MAX; rec = TICKS_MAX;
               on_lim = TICKS_MAX; rnd_cap = '1;
            end
            2: begin
               lvl_hi = LEVEL_W'($urandom_range(2000, 9000));
               lvl_lo = LEVEL_W'($urandom_range(0, lvl_hi));
               trip = 32'd3; rec = TICKS_MAX; on_lim = 32'd5; rnd_cap = 8'd1;
            end
            default: begin
               lvl_hi = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : LEVEL_W'($urandom_range(500, 60000));
               lvl_lo = LEVEL_W'($urandom_range(0, lvl_hi));
               trip   = $urandom_range(0, 8);
               rec    = $urandom_range(0, 8);
               on_lim = $urandom_range(1, 25);
               rnd_cap = ROUNDS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 4));
            end
         endcase
         // Upper bits of the narrow registers carry junk that must be dropped.
         junk = $urandom;
         write_csr(posm_pkg::CSR_MAX_LEVEL, {junk[31:16], lvl_hi});
         write_csr(posm_pkg::CSR_MIN_LEVEL, {junk[15:0], lvl_lo});
         write_csr(posm_pkg::CSR_TRIP_TICKS, trip);
         write_csr(posm_pkg::CSR_RECOVER_TICKS, rec);
         write_csr(posm_pkg::CSR_MAX_ON_TICKS, on_lim);
         write_csr(posm_pkg::CSR_MAX_ROUNDS, {junk[31:8], rnd_cap});

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) rq.opcode = posm_pkg::OP_TICK;
            else if (pick < 75) rq.opcode = posm_pkg::OP_LEVEL;
            else if (pick < 87) rq.opcode = posm_pkg::OP_START;
            else rq.opcode = posm_pkg::OP_STOP;
            // Readings cluster on the thresholds, with some anywhere in range.
            case ($urandom_range(0, 7))
               0: rq.level = '0;
               1: rq.level = cfg_min_level - 16'd1;
               2: rq.level = cfg_min_level;
               3: rq.level = cfg_max_level;
               4: rq.level = cfg_max_level + 16'd1;
               5, 6: rq.level = LEVEL_W'($urandom_range(0, cfg_min_level));
               default: rq.level = LEVEL_W'($urandom_range(0, 65535));
            endcase
            rq.level_valid = ($urandom_range(0, 9) != 0);
            rq.failsafe    = ($urandom_range(0, 99) < fs_pct);
            rq.quiet       = ($urandom_range(0, 99) < quiet_pct);
            send_request(rq, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/posm_pkg.sv
sv/pump_overheat_state_machine.sv
tb/tb_pump_overheat_state_machine.sv
